// ===== sv/ttu_pkg.sv =====
// ----------------------------------------------------------------------------
// ttu_pkg
// shared widths, radix codes, queue entry type and helpers for the text to
// unsigned parser
// ----------------------------------------------------------------------------
package ttu_pkg;

  localparam int VALUE_WIDTH  = 64;
  localparam int OFFSET_WIDTH = 16;
  localparam int CHAR_WIDTH   = 8;
  localparam int RADIX_WIDTH  = 6;
  localparam int DIGIT_WIDTH  = 6;
  localparam int PROD_WIDTH   = VALUE_WIDTH + RADIX_WIDTH;

  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_WIDTH   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_WIDTH   = $clog2(QUEUE_DEPTH + 1);

  // digit code for a byte that is no digit in any radix
  localparam logic [DIGIT_WIDTH-1:0] NO_DIGIT = '1;

  localparam logic [RADIX_WIDTH-1:0] RADIX_AUTO = RADIX_WIDTH'(0);
  localparam logic [RADIX_WIDTH-1:0] RADIX_BIN  = RADIX_WIDTH'(2);
  localparam logic [RADIX_WIDTH-1:0] RADIX_OCT  = RADIX_WIDTH'(8);
  localparam logic [RADIX_WIDTH-1:0] RADIX_DEC  = RADIX_WIDTH'(10);
  localparam logic [RADIX_WIDTH-1:0] RADIX_HEX  = RADIX_WIDTH'(16);
  localparam logic [RADIX_WIDTH-1:0] RADIX_MAX  = RADIX_WIDTH'(36);

  // classified character as it travels from front to back
  typedef struct packed {
    logic                   start;
    logic                   space;
    logic                   minus;
    logic                   plus;
    logic                   zero;
    logic                   letter_b;
    logic                   letter_x;
    logic [DIGIT_WIDTH-1:0] digit;
  } item_t;

  typedef struct packed {
    logic not_empty;
    logic full;
  } q_status_t;

  function automatic logic [RADIX_WIDTH-1:0] clamp_radix(input logic [RADIX_WIDTH-1:0] r);
    logic [RADIX_WIDTH-1:0] res;
    if (r < RADIX_BIN) begin
      res = RADIX_BIN;
    end else if (r > RADIX_MAX) begin
      res = RADIX_MAX;
    end else begin
      res = r;
    end
    return res;
  endfunction

endpackage

// ===== sv/ttu_ifs.sv =====
// ----------------------------------------------------------------------------
// ttu channel interfaces
// valid/ready channels for text characters in and parse results out
// ----------------------------------------------------------------------------
interface ttu_text_if;
  import ttu_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CHAR_WIDTH-1:0] text_char;
  logic                  text_start;

  modport source(output valid, text_char, text_start, input ready);
  modport sink(input valid, text_char, text_start, output ready);
endinterface

interface ttu_result_if;
  import ttu_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [VALUE_WIDTH-1:0]  value;
  logic [OFFSET_WIDTH-1:0] end_offset;
  logic                    overflowed;

  modport source(output valid, value, end_offset, overflowed, input ready);
  modport sink(input valid, value, end_offset, overflowed, output ready);
endinterface

// ===== sv/ttu_classify.sv =====
// ----------------------------------------------------------------------------
// ttu_classify
// front end: decodes one text byte into digit value and character classes
// ----------------------------------------------------------------------------
module ttu_classify (
  input  logic [ttu_pkg::CHAR_WIDTH-1:0] text_char,
  input  logic                           text_start,
  output ttu_pkg::item_t                 item
);
  import ttu_pkg::*;

  localparam logic [CHAR_WIDTH-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_WIDTH-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_WIDTH-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_WIDTH-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_WIDTH-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_WIDTH-1:0] CH_0     = 8'h30;
  localparam logic [CHAR_WIDTH-1:0] CH_9     = 8'h39;
  localparam logic [CHAR_WIDTH-1:0] CH_UP_A  = 8'h41;
  localparam logic [CHAR_WIDTH-1:0] CH_UP_B  = 8'h42;
  localparam logic [CHAR_WIDTH-1:0] CH_UP_X  = 8'h58;
  localparam logic [CHAR_WIDTH-1:0] CH_UP_Z  = 8'h5A;
  localparam logic [CHAR_WIDTH-1:0] CH_LO_A  = 8'h61;
  localparam logic [CHAR_WIDTH-1:0] CH_LO_B  = 8'h62;
  localparam logic [CHAR_WIDTH-1:0] CH_LO_X  = 8'h78;
  localparam logic [CHAR_WIDTH-1:0] CH_LO_Z  = 8'h7A;
  localparam logic [CHAR_WIDTH-1:0] LETTER_BASE = 8'd10;

  logic [CHAR_WIDTH-1:0] rel;

  always_comb begin
    rel = '0;
    priority if (text_char >= CH_0 && text_char <= CH_9) begin
      rel = text_char - CH_0;
    end else if (text_char >= CH_LO_A && text_char <= CH_LO_Z) begin
      rel = text_char - CH_LO_A + LETTER_BASE;
    end else if (text_char >= CH_UP_A && text_char <= CH_UP_Z) begin
      rel = text_char - CH_UP_A + LETTER_BASE;
    end else begin
      rel = CHAR_WIDTH'(NO_DIGIT);
    end

    item.start    = text_start;
    item.space    = (text_char == CH_SPACE) || (text_char >= CH_TAB && text_char <= CH_CR);
    item.minus    = (text_char == CH_MINUS);
    item.plus     = (text_char == CH_PLUS);
    item.zero     = (text_char == CH_0);
    item.letter_b = (text_char == CH_LO_B) || (text_char == CH_UP_B);
    item.letter_x = (text_char == CH_LO_X) || (text_char == CH_UP_X);
    item.digit    = rel[DIGIT_WIDTH-1:0];
  end

endmodule

// ===== sv/ttu_queue.sv =====
// ----------------------------------------------------------------------------
// ttu_queue
// short fifo of classified characters between front and back end
// ----------------------------------------------------------------------------
module ttu_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  ttu_pkg::item_t     wr_item,
  input  logic               pop,
  output ttu_pkg::item_t     rd_item,
  output ttu_pkg::q_status_t status
);
  import ttu_pkg::*;

  localparam logic [QPTR_WIDTH-1:0] LAST_PTR = QPTR_WIDTH'(QUEUE_DEPTH - 1);
  localparam logic [QCNT_WIDTH-1:0] FULL_CNT = QCNT_WIDTH'(QUEUE_DEPTH);

  item_t                 mem [QUEUE_DEPTH];
  logic [QPTR_WIDTH-1:0] wr_ptr;
  logic [QPTR_WIDTH-1:0] rd_ptr;
  logic [QCNT_WIDTH-1:0] count;

  assign status.not_empty = (count != '0);
  assign status.full      = (count == FULL_CNT);
  assign rd_item          = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== sv/ttu_exec.sv =====
// ----------------------------------------------------------------------------
// ttu_exec
// back end: parse state machine, multiply-accumulate with overflow check and
// result register
// ----------------------------------------------------------------------------
module ttu_exec (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [ttu_pkg::RADIX_WIDTH-1:0] radix,
  input  ttu_pkg::q_status_t              q_status,
  input  ttu_pkg::item_t                  item,
  output logic                            pop,
  ttu_result_if.source                    result
);
  import ttu_pkg::*;

  localparam logic [2:0] PH_SKIP   = 3'd0;
  localparam logic [2:0] PH_SIGN   = 3'd1;
  localparam logic [2:0] PH_ZERO   = 3'd2;
  localparam logic [2:0] PH_DIGITS = 3'd3;
  localparam logic [2:0] PH_OVER   = 3'd4;
  localparam logic [2:0] PH_DONE   = 3'd5;

  logic [2:0]              phase, phase_next, cur_phase;
  logic [VALUE_WIDTH-1:0]  acc, acc_next, cur_acc;
  logic [RADIX_WIDTH-1:0]  act_radix, act_radix_next, cur_radix;
  logic                    negative, negative_next, cur_neg;
  logic [OFFSET_WIDTH-1:0] char_count, char_count_next, cur_count;

  logic                    first;
  logic                    do_digit;
  logic                    emit;
  logic                    emit_ovf;
  logic [RADIX_WIDTH-1:0]  dig_radix;
  logic [PROD_WIDTH-1:0]   prod;
  logic [VALUE_WIDTH-1:0]  emit_value;

  logic                    res_valid;
  logic [VALUE_WIDTH-1:0]  res_value;
  logic [OFFSET_WIDTH-1:0] res_offset;
  logic                    res_ovf;

  assign pop = q_status.not_empty && (!res_valid || result.ready);

  always_comb begin
    // start of a new text clears the state ahead of this character
    cur_phase = item.start ? PH_SKIP : phase;
    cur_acc   = item.start ? '0 : acc;
    cur_radix = item.start ? RADIX_AUTO : act_radix;
    cur_neg   = item.start ? 1'b0 : negative;
    cur_count = item.start ? '0 : char_count;

    phase_next      = cur_phase;
    acc_next        = cur_acc;
    act_radix_next  = cur_radix;
    negative_next   = cur_neg;
    char_count_next = cur_count;
    first           = 1'b0;
    do_digit        = 1'b0;
    emit            = 1'b0;
    emit_ovf        = 1'b0;
    dig_radix       = cur_radix;

    unique case (cur_phase)
      PH_SKIP: begin
        priority if (item.space) begin
          phase_next = PH_SKIP;
        end else if (item.minus) begin
          negative_next = 1'b1;
          phase_next    = PH_SIGN;
        end else if (item.plus) begin
          phase_next = PH_SIGN;
        end else begin
          first = 1'b1;
        end
      end
      PH_SIGN: first = 1'b1;
      PH_ZERO: begin
        priority if ((cur_radix == RADIX_AUTO || cur_radix == RADIX_BIN) && item.letter_b) begin
          act_radix_next = RADIX_BIN;
          phase_next     = PH_DIGITS;
        end else if ((cur_radix == RADIX_AUTO || cur_radix == RADIX_HEX) && item.letter_x) begin
          act_radix_next = RADIX_HEX;
          phase_next     = PH_DIGITS;
        end else begin
          dig_radix      = (cur_radix == RADIX_AUTO) ? RADIX_OCT : clamp_radix(cur_radix);
          act_radix_next = dig_radix;
          phase_next     = PH_DIGITS;
          do_digit       = 1'b1;
        end
      end
      PH_DIGITS: do_digit = 1'b1;
      PH_OVER: begin
        if (item.digit >= cur_radix) begin
          emit     = 1'b1;
          emit_ovf = 1'b1;
        end
      end
      default: phase_next = cur_phase;
    endcase

    // first character after white space and sign
    if (first) begin
      if (item.zero) begin
        act_radix_next = radix;
        acc_next       = '0;
        phase_next     = PH_ZERO;
      end else begin
        dig_radix      = (radix == RADIX_AUTO) ? RADIX_DEC : clamp_radix(radix);
        act_radix_next = dig_radix;
        phase_next     = PH_DIGITS;
        do_digit       = 1'b1;
      end
    end

    // one digit step: acc * radix + digit, overflow when upper bits are set
    prod = PROD_WIDTH'(cur_acc) * PROD_WIDTH'(dig_radix) + PROD_WIDTH'(item.digit);
    if (do_digit) begin
      if (item.digit >= dig_radix) begin
        emit = 1'b1;
      end else if (prod[PROD_WIDTH-1:VALUE_WIDTH] == '0) begin
        acc_next = prod[VALUE_WIDTH-1:0];
      end else begin
        phase_next = PH_OVER;
      end
    end

    if (emit) begin
      phase_next = PH_DONE;
    end

    if (cur_phase != PH_DONE && cur_count != '1) begin
      char_count_next = cur_count + 1'b1;
    end

    if (emit_ovf) begin
      emit_value = '1;
    end else begin
      emit_value = cur_neg ? ('0 - cur_acc) : cur_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_SKIP;
      acc        <= '0;
      act_radix  <= RADIX_AUTO;
      negative   <= 1'b0;
      char_count <= '0;
      res_valid  <= 1'b0;
    end else begin
      if (pop) begin
        phase      <= phase_next;
        acc        <= acc_next;
        act_radix  <= act_radix_next;
        negative   <= negative_next;
        char_count <= char_count_next;
      end
      if (pop && emit) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      res_value  <= emit_value;
      res_offset <= cur_count;
      res_ovf    <= emit_ovf;
    end
  end

  assign result.valid      = res_valid;
  assign result.value      = res_value;
  assign result.end_offset = res_offset;
  assign result.overflowed = res_ovf;

endmodule

// ===== sv/text_to_unsigned_parser.sv =====
// ----------------------------------------------------------------------------
// text_to_unsigned_parser
// streaming text to unsigned integer converter with strtoul behaviour
// ----------------------------------------------------------------------------
// usage
//   text channel: one byte per transaction; text_start marks the first byte
//   of a new text and clears the parse state before that byte is handled
//   result channel: at most one transaction per text, at its terminating byte, with
//   the value, the index of the terminating byte and an overflow flag
//   radix register: written through radix_we / radix_wdata while idle;
//   0 detects the base from a 0x, 0b or 0 prefix
// result path: an accepted terminating byte is written to the queue; the
//   back end pops it once the result register is free or being taken and
//   registers the result
// throughput: one byte per cycle while the result channel does not stall,
//   set by the back end's 64 by 6 bit multiply-add loop on the accumulator
// reset: synchronous rst clears the queue, the result register and the
//   parse state, and sets radix to 0; the block then acts as if a new text
//   had just begun
// stall: while the result is not taken the back end holds, the queue fills
//   (two entries) and then the text channel drops ready
// ----------------------------------------------------------------------------
module text_to_unsigned_parser (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            radix_we,
  input  logic [ttu_pkg::RADIX_WIDTH-1:0] radix_wdata,
  ttu_text_if.sink                        text,
  ttu_result_if.source                    result
);
  import ttu_pkg::*;

  // configured base, sampled by the back end at the first byte past space and sign
  logic [RADIX_WIDTH-1:0] radix;

  item_t     in_item;
  item_t     q_item;
  q_status_t q_status;
  logic      push;
  logic      pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= RADIX_AUTO;
    end else if (radix_we) begin
      radix <= radix_wdata;
    end
  end

  // front end: accept and classify while the queue has room
  assign text.ready = !q_status.full;
  assign push       = text.valid && text.ready;

  ttu_classify u_classify (
    .text_char  (text.text_char),
    .text_start (text.text_start),
    .item       (in_item)
  );

  // decoupling queue so either side can stall on its own
  ttu_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_item (in_item),
    .pop     (pop),
    .rd_item (q_item),
    .status  (q_status)
  );

  // back end: state machine, accumulate and result register
  ttu_exec u_exec (
    .clk      (clk),
    .rst      (rst),
    .radix    (radix),
    .q_status (q_status),
    .item     (q_item),
    .pop      (pop),
    .result   (result)
  );

`ifndef NO_ASSERTIONS
  // overflow always reports the saturated value
  a_ovf_saturates: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.overflowed) |-> (&result.value))
    else $error("overflow result is not all ones");

  // a new result only appears after the back end consumed a transaction
  a_result_from_pop: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(pop))
    else $error("result appeared without a queue pop");

  // an accepted transaction is visible to the back end in the next cycle
  a_push_lands: assert property (@(posedge clk) disable iff (rst)
    push |=> q_status.not_empty)
    else $error("accepted transaction missing from queue");

  // full implies occupied
  a_full_not_empty: assert property (@(posedge clk) disable iff (rst)
    q_status.full |-> q_status.not_empty)
    else $error("queue status inconsistent");
`endif

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the text to unsigned parser: a byte-level predictor
// follows every accepted text byte, and each result transaction is checked
// against the oldest predicted parse under varied radix and idling
// ----------------------------------------------------------------------------
module tb;
  import ttu_pkg::*;

  localparam int CLK_HALF       = 6;
  localparam int RESET_CYCLES   = 3;
  localparam int SEG_COUNT      = 10;
  localparam int SEG_ITEMS      = 60;
  localparam int HOLD_CYCLES    = 400;
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int MAX_PRINTS     = 100;

  localparam logic [RADIX_WIDTH-1:0]  RADIX_ONE       = RADIX_WIDTH'(1);
  localparam logic [RADIX_WIDTH-1:0]  RADIX_TOP       = '1;
  localparam logic [VALUE_WIDTH-1:0]  VALUE_ALL_ONES  = '1;
  localparam logic [OFFSET_WIDTH-1:0] OFFSET_ALL_ONES = '1;
  localparam logic [CHAR_WIDTH-1:0]   CHAR_TAB        = 8'h09;
  localparam logic [CHAR_WIDTH-1:0]   CHAR_CR         = 8'h0d;
  localparam logic [CHAR_WIDTH-1:0]   CHAR_NUL        = 8'h00;

  // parser phases as the predictor tracks them
  typedef enum logic [2:0] {
    SCAN_SPACE,
    AFTER_SIGN,
    AFTER_ZERO,
    IN_DIGITS,
    SKIP_OVER,
    TEXT_DONE
  } scan_phase_e;

  typedef struct packed {
    logic [CHAR_WIDTH-1:0] ch;
    logic                  start;
  } text_item_t;

  typedef struct packed {
    logic [VALUE_WIDTH-1:0]  value;
    logic [OFFSET_WIDTH-1:0] end_offset;
    logic                    overflowed;
  } parse_result_t;

  logic clk;
  logic rst;
  logic radix_we;
  logic [RADIX_WIDTH-1:0] radix_wdata;

  ttu_text_if   text_ch();
  ttu_result_if result_ch();

  text_to_unsigned_parser uut (
    .clk        (clk),
    .rst        (rst),
    .radix_we   (radix_we),
    .radix_wdata(radix_wdata),
    .text       (text_ch),
    .result     (result_ch)
  );

  // bytes waiting to be driven, bytes of the text being assembled, parses due
  text_item_t            char_queue[$];
  logic [CHAR_WIDTH-1:0] draft[$];
  parse_result_t         parse_results_due[$];

  // idling knobs, percent of cycles
  int send_idle_pct = 0;
  int stall_pct     = 0;

  // long receiver hold-off, requested once by the stimulus
  bit hold_req   = 1'b0;
  bit hold_taken = 1'b0;
  int hold_left  = 0;

  int mismatch_count = 0;
  int stuck_cycles   = 0;

  // predictor state
  logic [RADIX_WIDTH-1:0]  radix_shadow = RADIX_AUTO;
  scan_phase_e             scan_phase   = SCAN_SPACE;
  logic [VALUE_WIDTH-1:0]  acc_value    = '0;
  logic [RADIX_WIDTH-1:0]  digit_base   = RADIX_AUTO;
  logic                    minus_seen   = 1'b0;
  logic [OFFSET_WIDTH-1:0] char_index   = '0;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // radix 0 and 1 fold to binary, anything past 36 folds to 36
  function automatic logic [RADIX_WIDTH-1:0] effective_base(input logic [RADIX_WIDTH-1:0] r);
    if (r < RADIX_BIN) begin
      return RADIX_BIN;
    end
    if (r > RADIX_MAX) begin
      return RADIX_MAX;
    end
    return r;
  endfunction

  // digit weight of a byte, letters either case; anything else is no digit
  function automatic logic [DIGIT_WIDTH-1:0] digit_value(input logic [CHAR_WIDTH-1:0] ch);
    if (ch >= "0" && ch <= "9") begin
      return DIGIT_WIDTH'(ch - "0");
    end
    if (ch >= "a" && ch <= "z") begin
      return DIGIT_WIDTH'(ch - "a" + 10);
    end
    if (ch >= "A" && ch <= "Z") begin
      return DIGIT_WIDTH'(ch - "A" + 10);
    end
    return NO_DIGIT;
  endfunction

  function automatic void clear_parse();
    scan_phase = SCAN_SPACE;
    acc_value  = '0;
    digit_base = RADIX_AUTO;
    minus_seen = 1'b0;
    char_index = '0;
  endfunction

  // advance the parse by one accepted byte; returns 1 when a result is due
  function automatic bit parse_char(input logic start, input logic [CHAR_WIDTH-1:0] ch,
                                    output parse_result_t res);
    logic [DIGIT_WIDTH-1:0] d;
    logic [VALUE_WIDTH-1:0] base, top_quot, top_rem;
    bit done, ovf, digit_step;
    done       = 1'b0;
    ovf        = 1'b0;
    digit_step = 1'b0;
    res        = '0;
    if (start) begin
      clear_parse();
    end
    // bytes after the terminator are dropped until the next text
    if (scan_phase == TEXT_DONE) begin
      return 1'b0;
    end
    d = digit_value(ch);
    case (scan_phase)
      SCAN_SPACE, AFTER_SIGN: begin
        if (scan_phase == SCAN_SPACE && (ch == " " || (ch >= CHAR_TAB && ch <= CHAR_CR))) begin
          // leading white space
        end else if (scan_phase == SCAN_SPACE && ch == "-") begin
          minus_seen = 1'b1;
          scan_phase = AFTER_SIGN;
        end else if (scan_phase == SCAN_SPACE && ch == "+") begin
          scan_phase = AFTER_SIGN;
        end else if (ch == "0") begin
          // raw register kept until the prefix letter is known
          digit_base = radix_shadow;
          acc_value  = '0;
          scan_phase = AFTER_ZERO;
        end else begin
          digit_base = (radix_shadow == RADIX_AUTO) ? RADIX_DEC : effective_base(radix_shadow);
          scan_phase = IN_DIGITS;
          digit_step = 1'b1;
        end
      end
      AFTER_ZERO: begin
        if ((digit_base == RADIX_AUTO || digit_base == RADIX_BIN) && (ch == "b" || ch == "B")) begin
          digit_base = RADIX_BIN;
          scan_phase = IN_DIGITS;
        end else if ((digit_base == RADIX_AUTO || digit_base == RADIX_HEX) &&
                     (ch == "x" || ch == "X")) begin
          digit_base = RADIX_HEX;
          scan_phase = IN_DIGITS;
        end else begin
          digit_base = (digit_base == RADIX_AUTO) ? RADIX_OCT : effective_base(digit_base);
          scan_phase = IN_DIGITS;
          digit_step = 1'b1;
        end
      end
      IN_DIGITS: begin
        digit_step = 1'b1;
      end
      SKIP_OVER: begin
        // overflowed: swallow digits, finish at the first non-digit
        if (d >= digit_base) begin
          done = 1'b1;
          ovf  = 1'b1;
        end
      end
      default: begin
      end
    endcase
    if (digit_step) begin
      base     = VALUE_WIDTH'(digit_base);
      top_quot = VALUE_ALL_ONES / base;
      top_rem  = VALUE_ALL_ONES % base;
      if (d >= digit_base) begin
        done = 1'b1;
      end else if (acc_value < top_quot || (acc_value == top_quot && d <= top_rem)) begin
        acc_value = acc_value * base + VALUE_WIDTH'(d);
      end else begin
        scan_phase = SKIP_OVER;
      end
    end
    if (done) begin
      // all ones on overflow is never negated
      res.value      = ovf ? VALUE_ALL_ONES : (minus_seen ? VALUE_WIDTH'(0) - acc_value : acc_value);
      res.end_offset = char_index;
      res.overflowed = ovf;
      scan_phase     = TEXT_DONE;
    end
    if (char_index != OFFSET_ALL_ONES) begin
      char_index = char_index + 1'b1;
    end
    return done;
  endfunction

  // ---------------------------------------------------------------------------
  // text assembly
  // ---------------------------------------------------------------------------

  function automatic logic [CHAR_WIDTH-1:0] digit_char(input int v);
    if (v < 10) begin
      return CHAR_WIDTH'("0" + v);
    end
    return CHAR_WIDTH'(($urandom_range(0, 1) ? "a" : "A") + v - 10);
  endfunction

  function automatic logic [CHAR_WIDTH-1:0] random_space();
    int r;
    r = $urandom_range(0, 5);
    return (r == 0) ? CHAR_WIDTH'(" ") : CHAR_WIDTH'(CHAR_TAB + r - 1);
  endfunction

  task automatic add_string(input string s);
    foreach (s[i]) begin
      draft.push_back(s[i]);
    end
  endtask

  // move the draft to the send queue; only its first byte may carry the start
  task automatic flush_text(input bit lead_start);
    foreach (draft[i]) begin
      char_queue.push_back('{ch: draft[i], start: (i == 0) ? lead_start : 1'b0});
    end
    draft.delete();
  endtask

  // one random text: mostly well formed with random content, some near the
  // 64-bit limit, some with no terminator, some plain noise
  task automatic queue_random_text(input logic [RADIX_WIDTH-1:0] cfg);
    int kind, base, last, sign;
    int digits[$];
    logic [VALUE_WIDTH-1:0] rest;
    logic [CHAR_WIDTH-1:0] term;
    kind = $urandom_range(0, 99);
    if (kind < 10) begin
      repeat ($urandom_range(1, 6)) draft.push_back(CHAR_WIDTH'($urandom_range(0, 255)));
      flush_text(1'($urandom_range(0, 1)));
      return;
    end
    base = effective_base(cfg);
    repeat ($urandom_range(0, 3)) draft.push_back(random_space());
    sign = $urandom_range(0, 3);
    if (sign < 2) begin
      draft.push_back(sign == 0 ? "-" : "+");
      // white space after the sign ends the number
      if ($urandom_range(0, 9) == 0) begin
        draft.push_back(random_space());
      end
    end
    if (cfg == RADIX_AUTO) begin
      case ($urandom_range(0, 3))
        0: begin
          add_string($urandom_range(0, 1) ? "0x" : "0X");
          base = RADIX_HEX;
        end
        1: begin
          add_string($urandom_range(0, 1) ? "0b" : "0B");
          base = RADIX_BIN;
        end
        2: begin
          add_string("0");
          base = RADIX_OCT;
        end
        default: begin
          base = RADIX_DEC;
        end
      endcase
    end else if ((cfg == RADIX_HEX || cfg == RADIX_BIN) && $urandom_range(0, 1)) begin
      add_string(cfg == RADIX_HEX ? "0x" : "0b");
    end
    if (kind < 20) begin
      // digits of the largest value, then exact, past it by a longer string,
      // or past it by a larger last digit
      rest = VALUE_ALL_ONES;
      while (rest != 0) begin
        digits.push_front(int'(rest % base));
        rest = rest / base;
      end
      last = digits[digits.size()-1];
      case ($urandom_range(0, 2))
        1: repeat ($urandom_range(1, 3)) digits.push_back($urandom_range(0, base - 1));
        2: begin
          if (last < base - 1) begin
            digits[digits.size()-1] = $urandom_range(last + 1, base - 1);
          end else begin
            digits.push_back($urandom_range(0, base - 1));
          end
        end
        default: begin
        end
      endcase
    end else begin
      repeat ($urandom_range(0, 12)) digits.push_back($urandom_range(0, base - 1));
    end
    foreach (digits[i]) begin
      draft.push_back(digit_char(digits[i]));
    end
    // a tenth of the texts are cut short and run into the next start
    if (kind < 90) begin
      do begin
        term = CHAR_WIDTH'($urandom_range(0, 255));
      end while (digit_value(term) < base);
      draft.push_back(term);
    end
    flush_text(1'b1);
    // stray bytes after the result, to be ignored
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 2)) draft.push_back(CHAR_WIDTH'($urandom_range(0, 255)));
      flush_text(1'b0);
    end
  endtask

  task automatic flag_mismatch(input string what, input logic [VALUE_WIDTH-1:0] got,
                               input logic [VALUE_WIDTH-1:0] want);
    if (mismatch_count < MAX_PRINTS) begin
      $display("%0t mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
    end
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------------
  // clock
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // text driver: pulls the next byte once the current transaction is taken
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : text_driver
    text_item_t nxt;
    if (rst) begin
      text_ch.valid <= 1'b0;
    end else if (!text_ch.valid || text_ch.ready) begin
      if (char_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        nxt = char_queue.pop_front();
        text_ch.valid      <= 1'b1;
        text_ch.text_char  <= nxt.ch;
        text_ch.text_start <= nxt.start;
      end else begin
        text_ch.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result sink: random stalls plus one long hold-off so the block backs up
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_sink
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else if (hold_req && !hold_taken) begin
      hold_taken      <= 1'b1;
      hold_left       <= HOLD_CYCLES;
      result_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left       <= hold_left - 1;
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: checks result transactions, then predicts from text transactions
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    parse_result_t due, fresh;
    if (rst) begin
      radix_shadow = RADIX_AUTO;
      clear_parse();
    end else begin
      if (radix_we) begin
        radix_shadow = radix_wdata;
      end
      if (result_ch.valid && result_ch.ready) begin
        if (parse_results_due.size() == 0) begin
          flag_mismatch("unexpected result", result_ch.value, '0);
        end else begin
          due = parse_results_due.pop_front();
          if (result_ch.value !== due.value) begin
            flag_mismatch("value", result_ch.value, due.value);
          end
          if (result_ch.end_offset !== due.end_offset) begin
            flag_mismatch("end_offset", VALUE_WIDTH'(result_ch.end_offset),
                          VALUE_WIDTH'(due.end_offset));
          end
          if (result_ch.overflowed !== due.overflowed) begin
            flag_mismatch("overflowed", VALUE_WIDTH'(result_ch.overflowed),
                          VALUE_WIDTH'(due.overflowed));
          end
        end
      end
      if (text_ch.valid && text_ch.ready) begin
        if (parse_char(text_ch.text_start, text_ch.text_char, fresh)) begin
          parse_results_due.push_back(fresh);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: too long without any transaction on either channel
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watchdog
    if (rst || (text_ch.valid && text_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t watchdog: no transaction for %0d cycles", $realtime, stuck_cycles);
      $display("status: fail");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus: segments with their own radix and idling mix
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int seg, seg_base;
    logic [RADIX_WIDTH-1:0] seg_radix;
    // known values on every input from time zero
    rst                = 1'b1;
    radix_we           = 1'b0;
    radix_wdata        = '0;
    text_ch.valid      = 1'b0;
    text_ch.text_char  = '0;
    text_ch.text_start = 1'b0;
    result_ch.ready    = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    for (seg = 0; seg < SEG_COUNT; seg++) begin
      case (seg)
        0:       seg_radix = RADIX_AUTO;
        1:       seg_radix = RADIX_HEX;
        2:       seg_radix = RADIX_BIN;
        3:       seg_radix = RADIX_MAX;
        4:       seg_radix = RADIX_TOP;
        5:       seg_radix = RADIX_ONE;
        6:       seg_radix = RADIX_DEC;
        7:       seg_radix = RADIX_AUTO;
        8:       seg_radix = RADIX_OCT;
        default: seg_radix = RADIX_WIDTH'($urandom_range(0, 63));
      endcase
      @(posedge clk);
      // the first segment runs on the reset radix
      if (seg != 0) begin
        radix_we    <= 1'b1;
        radix_wdata <= seg_radix;
        @(posedge clk);
        radix_we    <= 1'b0;
      end
      // idling mix: none, sender gaps, receiver stalls, both
      case (seg % 4)
        0: begin
          send_idle_pct <= 0;
          stall_pct     <= 0;
        end
        1: begin
          send_idle_pct <= 81;
          stall_pct     <= 0;
        end
        2: begin
          send_idle_pct <= 0;
          stall_pct     <= 81;
        end
        default: begin
          send_idle_pct <= 33;
          stall_pct     <= 33;
        end
      endcase

      // queue the whole segment between edges
      @(negedge clk);
      if (seg == 0) begin
        // first byte after reset carries no start
        add_string(" -0x1Fg");
        flush_text(1'b0);
        // white space after sign, then a byte that must be ignored
        add_string("+ 5");
        flush_text(1'b1);
        // prefixes with no digits behind them
        add_string("0xz");
        flush_text(1'b1);
        add_string("0b2");
        flush_text(1'b1);
        // high byte, no digits at all
        draft.push_back(8'hff);
        flush_text(1'b1);
        // octal by leading zero, closed by NUL
        add_string("017");
        draft.push_back(CHAR_NUL);
        flush_text(1'b1);
        add_string("\r\n9");
        draft.push_back(8'h80);
        flush_text(1'b1);
      end
      seg_base = char_queue.size();
      while (char_queue.size() - seg_base < SEG_ITEMS) begin
        queue_random_text(seg_radix);
      end
      if (seg == 0) begin
        @(posedge clk);
        hold_req <= 1'b1;
      end

      // drain: everything sent, every parse seen, then let the pipeline settle
      while (char_queue.size() != 0 || text_ch.valid || parse_results_due.size() != 0) begin
        @(posedge clk);
      end
      repeat (SETTLE_CYCLES) @(posedge clk);
    end

    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
